>>> design/cac_pkg.sv
// Shared types and constants for the climate actuator arbiter.
package cac_pkg;

	localparam int unsigned DUTY_IN_W = 10;
	localparam int unsigned TICKS_W   = 16;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DAT_W = 16;
	localparam int unsigned S_DATA_W  = 80;
	localparam int unsigned M_DATA_W  = 24;

	localparam logic [DUTY_IN_W-1:0] RH_SEQ_MIN  = 10'd50;
	localparam logic [DUTY_IN_W-1:0] RH_COOP_MIN = 10'd100;

	localparam logic [DUTY_IN_W-1:0] RST_FAN_MIN   = 10'd200;
	localparam logic                 RST_PARALLEL  = 1'b0;
	localparam logic [DUTY_IN_W-1:0] RST_COOP_TH   = 10'd300;
	localparam logic [DUTY_IN_W-1:0] RST_HUM_CAP   = 10'd500;
	localparam logic [TICKS_W-1:0]   RST_ALT_TICKS = 16'd30;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FAN_MIN_DUTY        = 3'd0,
		REG_ALLOW_PARALLEL      = 3'd1,
		REG_COOPERATE_THRESHOLD = 3'd2,
		REG_HUM_COOP_CAP        = 3'd3,
		REG_ALTERNATE_TICKS     = 3'd4
	} cfg_reg_t;

	typedef enum logic [2:0] {
		RSN_NORMAL     = 3'd0,
		RSN_CO2_PURGE  = 3'd1,
		RSN_RH_CRIT    = 3'd2,
		RSN_COOP_CAP   = 3'd3,
		RSN_CONDENSATE = 3'd4,
		RSN_BIAS_FAN   = 3'd5,
		RSN_BIAS_HUM   = 3'd6,
		RSN_SAFE       = 3'd7
	} reason_t;

	typedef struct packed {
		logic [DUTY_IN_W-1:0] fan_min_duty;
		logic                 allow_parallel;
		logic [DUTY_IN_W-1:0] cooperate_threshold;
		logic [DUTY_IN_W-1:0] hum_coop_cap;
	} arb_cfg_t;

	typedef struct packed {
		logic [DUTY_IN_W-1:0] condensate_hum_limit;
		logic [DUTY_IN_W-1:0] condensate_fan_floor;
		logic [DUTY_IN_W-1:0] safety_hum_cap;
		logic [DUTY_IN_W-1:0] safety_exhaust_floor;
		logic [2:0]           limit_flags;
		logic [DUTY_IN_W-1:0] temp_req;
		logic [DUTY_IN_W-1:0] co2_req;
		logic [DUTY_IN_W-1:0] rh_req;
		logic [2:0]           loop_enables;
		logic                 sensors_missing;
	} tick_t;

	typedef struct packed {
		reason_t              reason;
		logic [DUTY_IN_W-1:0] hum_duty;
		logic [DUTY_IN_W-1:0] fan_duty;
	} result_t;

	typedef struct packed {
		logic prio_eff;
		logic busy;
	} seq_view_t;

endpackage

>>> design/cac_seq.sv
// Sequencing tick counter, priority flag and phase recompute unit.
module cac_seq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [cac_pkg::TICKS_W-1:0]   alternate_ticks,
	input  logic                          recompute,
	input  logic                          step,
	output cac_pkg::seq_view_t            view
);

	localparam int unsigned TW = cac_pkg::TICKS_W;

	logic [TW-1:0]          seq_q;
	logic [TW-1:0]          phase_q;
	logic                   prio_q;
	logic                   busy_q;
	logic [$clog2(TW)-1:0]  cnt_q;
	logic [TW-1:0]          rem_q;

	logic [TW:0]   period;
	logic [TW-1:0] seq_next;
	logic [TW:0]   phase_inc;
	logic [TW-1:0] phase_next;
	logic [TW:0]   trial;
	logic [TW-1:0] rem_next;

	assign period     = (alternate_ticks == '0) ? {1'b1, {TW{1'b0}}} : {1'b0, alternate_ticks};
	assign seq_next   = seq_q + 1'b1;
	assign phase_inc  = {1'b0, phase_q} + 1'b1;
	assign phase_next = ((seq_next == '0) || (phase_inc == period)) ? '0 : phase_inc[TW-1:0];
	assign trial      = {rem_q, seq_q[~cnt_q]};
	assign rem_next   = (trial >= period) ? TW'(trial - period) : trial[TW-1:0];

	assign view.prio_eff = prio_q ^ (phase_next == '0);
	assign view.busy     = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q   <= '0;
			phase_q <= '0;
			prio_q  <= 1'b1;
			busy_q  <= 1'b0;
			cnt_q   <= '0;
		end else if (recompute) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == '1) begin
				busy_q  <= 1'b0;
				phase_q <= rem_next;
			end
		end else if (step) begin
			seq_q   <= seq_next;
			phase_q <= phase_next;
			prio_q  <= view.prio_eff;
		end
	end

	always_ff @(posedge clk) begin
		if (recompute) begin
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= rem_next;
		end
	end

endmodule

>>> design/cac_arbiter.sv
// Ordered override chain that merges loop demands into fan and humidifier duties.
module cac_arbiter #(
	parameter int unsigned DUTY_FULL = 1000
) (
	input  cac_pkg::tick_t      tick,
	input  cac_pkg::arb_cfg_t   cfg,
	input  logic                prio_eff,
	output logic                seq_step,
	output cac_pkg::result_t    result
);

	localparam int unsigned IW = cac_pkg::DUTY_IN_W;
	localparam int unsigned FW = $clog2(DUTY_FULL + 1);
	localparam int unsigned DW = (FW > IW) ? FW : IW;
	localparam logic [DW-1:0] FULL = DW'(DUTY_FULL);

	logic          rh_en, co2_en, temp_en, co2_alarm, rh_crit, cond;
	logic          coop;
	logic [DW-1:0] fan_min, fan, hum;
	logic [DW-1:0] fan_clamp, hum_clamp;
	cac_pkg::reason_t reason;

	assign rh_en     = tick.loop_enables[0];
	assign co2_en    = tick.loop_enables[1];
	assign temp_en   = tick.loop_enables[2];
	assign co2_alarm = tick.limit_flags[0];
	assign rh_crit   = tick.limit_flags[1];
	assign cond      = tick.limit_flags[2];
	assign fan_min   = DW'(cfg.fan_min_duty);

	assign seq_step = !tick.sensors_missing && !cfg.allow_parallel && rh_en && co2_en
		&& (tick.rh_req > cac_pkg::RH_SEQ_MIN)
		&& (tick.co2_req > cfg.cooperate_threshold);
	assign coop = cfg.allow_parallel && rh_en && co2_en && !co2_alarm
		&& (tick.rh_req > cac_pkg::RH_COOP_MIN)
		&& (tick.co2_req > cfg.cooperate_threshold);

	always_comb begin
		fan    = co2_en ? DW'(tick.co2_req) : fan_min;
		hum    = rh_en ? DW'(tick.rh_req) : '0;
		reason = cac_pkg::RSN_NORMAL;
		if (tick.sensors_missing) begin
			fan    = fan_min;
			hum    = '0;
			reason = cac_pkg::RSN_SAFE;
		end else begin
			if (temp_en && (DW'(tick.temp_req) > fan)) begin
				fan = DW'(tick.temp_req);
			end
			if (co2_alarm) begin
				fan    = FULL;
				reason = cac_pkg::RSN_CO2_PURGE;
			end
			if (DW'(tick.safety_exhaust_floor) > fan) begin
				fan = DW'(tick.safety_exhaust_floor);
			end
			if (rh_crit) begin
				hum    = '0;
				reason = cac_pkg::RSN_RH_CRIT;
			end
			if (DW'(tick.safety_hum_cap) < hum) begin
				hum = DW'(tick.safety_hum_cap);
			end
			if (cond) begin
				if (DW'(tick.condensate_fan_floor) > fan) begin
					fan = DW'(tick.condensate_fan_floor);
				end
				if (hum > DW'(tick.condensate_hum_limit)) begin
					hum = DW'(tick.condensate_hum_limit);
				end
				reason = cac_pkg::RSN_CONDENSATE;
			end
			if (seq_step) begin
				if (prio_eff) begin
					hum    = hum >> 2;
					reason = cac_pkg::RSN_BIAS_FAN;
				end else begin
					fan = fan >> 1;
					if (fan < fan_min) begin
						fan = fan_min;
					end
					reason = cac_pkg::RSN_BIAS_HUM;
				end
			end
			if (coop && (hum > DW'(cfg.hum_coop_cap))) begin
				hum    = DW'(cfg.hum_coop_cap);
				reason = cac_pkg::RSN_COOP_CAP;
			end
		end
	end

	assign fan_clamp = (fan > FULL) ? FULL : fan;
	assign hum_clamp = (hum > FULL) ? FULL : hum;

	assign result.fan_duty = fan_clamp[IW-1:0];
	assign result.hum_duty = hum_clamp[IW-1:0];
	assign result.reason   = reason;

endmodule

>>> design/climate_actuator_arbiter_top.sv
// Top level of the climate actuator arbiter: channels, registers and pipeline.
//
// One control tick enters on the s_ stream channel and one result leaves on the
// m_ stream channel per tick. Configuration registers are written through the
// cfg_ channel (cfg_index selects the register, cfg_data carries the value);
// write only while no tick is in flight.
// An accepted tick is held in the input register and its result in the result
// register, which drives m_tvalid. One tick per cycle while m_tready is high
// and no recompute runs; input and result registers are the only stages, with
// the override chain between them. Writing alternate_ticks starts a remainder
// pass over the tick counter in the sequencer; s_tready is low while it runs.
// Reset loads the register defaults, clears the tick counter, sets fan
// priority and empties both stages.
// When the receiver holds m_tready low the result holds, the input register
// fills, and s_tready drops until the result is taken.
module climate_actuator_arbiter_top #(
	parameter int unsigned DUTY_FULL = 1000
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// sensors_missing, loop_enables, rh_req, co2_req, temp_req,
	// limit_flags, safety_exhaust_floor, safety_hum_cap,
	// condensate_fan_floor, condensate_hum_limit, zero pad
	input  logic [cac_pkg::S_DATA_W-1:0]    s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// fan_duty, hum_duty, reason, zero pad
	output logic [cac_pkg::M_DATA_W-1:0]    m_tdata,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [cac_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [cac_pkg::CFG_DAT_W-1:0]   cfg_data
);

	localparam int unsigned TW = cac_pkg::TICKS_W;
	localparam int unsigned TICK_W = $bits(cac_pkg::tick_t);
	localparam int unsigned RES_W  = $bits(cac_pkg::result_t);

	cac_pkg::arb_cfg_t    cfg_q;
	logic [TW-1:0]        alt_ticks_q;
	logic                 cfg_wr;
	logic                 recompute;

	logic                 valid_s1;
	cac_pkg::tick_t       tick_s1;
	logic                 adv;
	logic                 seq_step;
	cac_pkg::seq_view_t   seq_view;
	cac_pkg::result_t     result;
	cac_pkg::result_t     result_s2;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign recompute = cfg_wr && (cfg_index == cac_pkg::REG_ALTERNATE_TICKS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fan_min_duty        <= cac_pkg::RST_FAN_MIN;
			cfg_q.allow_parallel      <= cac_pkg::RST_PARALLEL;
			cfg_q.cooperate_threshold <= cac_pkg::RST_COOP_TH;
			cfg_q.hum_coop_cap        <= cac_pkg::RST_HUM_CAP;
			alt_ticks_q               <= cac_pkg::RST_ALT_TICKS;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				cac_pkg::REG_FAN_MIN_DUTY: begin
					cfg_q.fan_min_duty <= cfg_data[cac_pkg::DUTY_IN_W-1:0];
				end
				cac_pkg::REG_ALLOW_PARALLEL: begin
					cfg_q.allow_parallel <= cfg_data[0];
				end
				cac_pkg::REG_COOPERATE_THRESHOLD: begin
					cfg_q.cooperate_threshold <= cfg_data[cac_pkg::DUTY_IN_W-1:0];
				end
				cac_pkg::REG_HUM_COOP_CAP: begin
					cfg_q.hum_coop_cap <= cfg_data[cac_pkg::DUTY_IN_W-1:0];
				end
				cac_pkg::REG_ALTERNATE_TICKS: begin
					alt_ticks_q <= cfg_data[TW-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign adv      = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = (!valid_s1 || adv) && !seq_view.busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			tick_s1 <= s_tdata[TICK_W-1:0];
		end
		if (adv) begin
			result_s2 <= result;
		end
	end

	cac_arbiter #(
		.DUTY_FULL(DUTY_FULL)
	) u_arbiter (
		.tick     (tick_s1),
		.cfg      (cfg_q),
		.prio_eff (seq_view.prio_eff),
		.seq_step (seq_step),
		.result   (result)
	);

	cac_seq u_seq (
		.clk             (clk),
		.arst_n          (arst_n),
		.alternate_ticks (alt_ticks_q),
		.recompute       (recompute),
		.step            (adv && seq_step),
		.view            (seq_view)
	);

	assign m_tdata = {{(cac_pkg::M_DATA_W - RES_W){1'b0}}, result_s2};

`ifndef SYNTH
	a_busy_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		seq_view.busy |-> !s_tready)
		else $error("input taken during phase recompute");

	a_recompute_starts: assert property (@(posedge clk) disable iff (!arst_n)
		recompute |=> seq_view.busy)
		else $error("phase recompute did not start");

	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(tick_s1))
		else $error("input register lost a stalled tick");

	a_safe_hum_off: assert property (@(posedge clk) disable iff (!arst_n)
		adv && tick_s1.sensors_missing |=> result_s2.reason == cac_pkg::RSN_SAFE
			&& result_s2.hum_duty == '0)
		else $error("safe mode result wrong");

	a_no_seq_in_safe: assert property (@(posedge clk) disable iff (!arst_n)
		tick_s1.sensors_missing && valid_s1 |-> !seq_step)
		else $error("sequencing advanced in safe mode");
`endif

endmodule
